FILE: design/sws_pkg.sv
// Shared codes, types and helpers for the stop-and-wait sender.
package sws_pkg;

    localparam int KIND_W    = 2;
    localparam int WORD_W    = 16;
    localparam int TIMER_W   = 16;
    localparam int MISS_W    = 8;
    localparam int IDX_W     = 3;
    localparam int ACKNUM_W  = 32;
    localparam int OUTCOME_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_SEND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd2;

    // result outcomes
    localparam logic [OUTCOME_W-1:0] OUTCOME_NONE   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_ACKED  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_GAVEUP = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 2'd1;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [MISS_W-1:0]  RETRY_RESET   = 8'd5;

    // reply halfword positions and flag
    localparam logic [IDX_W-1:0]  IDX_ACK_LO = 3'd2;
    localparam logic [IDX_W-1:0]  IDX_ACK_HI = 3'd3;
    localparam logic [IDX_W-1:0]  IDX_FLAGS  = 3'd4;
    localparam logic [IDX_W-1:0]  IDX_MAX    = 3'd7;
    localparam int                ACK_BIT    = 4;
    localparam logic [WORD_W-1:0] SUM_GOOD   = 16'hffff;

    typedef struct packed {
        logic                 send;
        logic                 send_seq;
        logic [OUTCOME_W-1:0] outcome;
    } t_result;

    // ones' complement add with end-around carry
    function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        ones_add = s[WORD_W] ? (s[WORD_W-1:0] + 1'b1) : s[WORD_W-1:0];
    endfunction

endpackage

FILE: design/sws_core.sv
// Protocol state of the sender and the one-pass update for each item.
module sws_core import sws_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [WORD_W-1:0]     i_word,
    input  logic                  i_last,
    input  logic [TIMER_W-1:0]    i_timeout_ticks,
    input  logic [MISS_W-1:0]     i_retry_limit,
    output t_result               o_result
);

    logic                r_waiting,  n_waiting;
    logic                r_seq,      n_seq;
    logic [TIMER_W-1:0]  r_timer,    n_timer;
    logic [MISS_W-1:0]   r_miss,     n_miss;
    logic [IDX_W-1:0]    r_idx,      n_idx;
    logic [WORD_W-1:0]   r_sum,      n_sum;
    logic [ACKNUM_W-1:0] r_ack_num,  n_ack_num;
    logic                r_ack_flag, n_ack_flag;

    logic [TIMER_W:0]    tick_next;
    logic [TIMER_W:0]    tick_lim;
    logic [MISS_W-1:0]   miss_next;
    logic [MISS_W-1:0]   retry_lim;
    logic [WORD_W-1:0]   sum_new;
    logic [ACKNUM_W-1:0] ack_num_new;
    logic                ack_flag_new;
    logic                bad_sum;
    logic                stale;

    always_comb begin
        tick_next = {1'b0, r_timer} + 1'b1;
        tick_lim  = (i_timeout_ticks == '0) ? {{TIMER_W{1'b0}}, 1'b1}
                                            : {1'b0, i_timeout_ticks};
        miss_next = r_miss + 1'b1;
        retry_lim = (i_retry_limit == '0) ? {{(MISS_W-1){1'b0}}, 1'b1} : i_retry_limit;

        sum_new      = ones_add(r_sum, i_word);
        ack_num_new  = r_ack_num;
        ack_flag_new = r_ack_flag;
        if (r_idx == IDX_ACK_LO) begin
            ack_num_new = {r_ack_num[ACKNUM_W-1:WORD_W], i_word};
        end else if (r_idx == IDX_ACK_HI) begin
            ack_num_new = {i_word, r_ack_num[WORD_W-1:0]};
        end else if (r_idx == IDX_FLAGS) begin
            ack_flag_new = i_word[ACK_BIT];
        end
        bad_sum = (sum_new != SUM_GOOD);
        stale   = ack_flag_new && (ack_num_new != {{(ACKNUM_W-1){1'b0}}, r_seq});
    end

    always_comb begin
        n_waiting  = r_waiting;
        n_seq      = r_seq;
        n_timer    = r_timer;
        n_miss     = r_miss;
        n_idx      = r_idx;
        n_sum      = r_sum;
        n_ack_num  = r_ack_num;
        n_ack_flag = r_ack_flag;
        o_result   = '0;

        unique case (i_kind)
            KIND_SEND: begin
                if (!r_waiting) begin
                    n_waiting     = 1'b1;
                    n_timer       = '0;
                    n_miss        = '0;
                    o_result.send = 1'b1;
                end
            end
            KIND_TICK: begin
                if (r_waiting) begin
                    if (tick_next >= tick_lim) begin
                        n_timer       = '0;
                        n_miss        = miss_next;
                        o_result.send = 1'b1;
                        if (miss_next >= retry_lim) begin
                            o_result.outcome = OUTCOME_GAVEUP;
                            n_waiting        = 1'b0;
                        end
                    end else begin
                        n_timer = tick_next[TIMER_W-1:0];
                    end
                end
            end
            KIND_REPLY: begin
                n_sum      = sum_new;
                n_ack_num  = ack_num_new;
                n_ack_flag = ack_flag_new;
                if (r_idx != IDX_MAX) begin
                    n_idx = r_idx + 1'b1;
                end
                if (i_last) begin
                    if (r_waiting) begin
                        n_timer = '0;
                        if (bad_sum || stale) begin
                            o_result.send = 1'b1;
                        end else if (ack_flag_new) begin
                            o_result.outcome = OUTCOME_ACKED;
                            n_waiting        = 1'b0;
                            n_seq            = ~r_seq;
                        end
                    end
                    // frame done: clear sum and captures
                    n_idx      = '0;
                    n_sum      = '0;
                    n_ack_num  = '0;
                    n_ack_flag = 1'b0;
                end
            end
            default: begin
            end
        endcase

        o_result.send_seq = o_result.send & r_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting  <= 1'b0;
            r_seq      <= 1'b0;
            r_timer    <= '0;
            r_miss     <= '0;
            r_idx      <= '0;
            r_sum      <= '0;
            r_ack_num  <= '0;
            r_ack_flag <= 1'b0;
        end else if (i_go) begin
            r_waiting  <= n_waiting;
            r_seq      <= n_seq;
            r_timer    <= n_timer;
            r_miss     <= n_miss;
            r_idx      <= n_idx;
            r_sum      <= n_sum;
            r_ack_num  <= n_ack_num;
            r_ack_flag <= n_ack_flag;
        end
    end

endmodule

FILE: design/stop_and_wait_sender.sv
// Top level of the stop-and-wait ARQ sender with alternating sequence bit.
//
// Input channel (i_valid / o_stall) carries one beat per event: a send
// request, a time tick or one reply halfword (i_last on the final one).
// Output channel (o_valid / i_stall) returns exactly one result beat per
// input beat: o_send asks for the held packet to go out with o_send_seq,
// o_outcome reports acknowledged or gave up.
// A beat is registered on entry, processed against the protocol state once
// the skid register is free, and its result is registered.
// Throughput is one beat per cycle while o_stall is low; the single protocol state
// update per beat (one ones' complement add, timer and ack compares) sets that rate.
// When the receiver stalls, results collect in the output register and a
// one-entry skid register; o_stall rises only when both are full and a
// beat is waiting in the input register.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
// timeout in ticks (index 0) and the retry limit (index 1); other indexes
// are dropped. Reset makes the block idle with sequence bit 0, timeout
// 2000 and retry limit 5, and empties all pipeline registers.
module stop_and_wait_sender import sws_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [WORD_W-1:0]     i_word,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_send,
    output logic                  o_send_seq,
    output logic [OUTCOME_W-1:0]  o_outcome,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    logic [TIMER_W-1:0] r_timeout_ticks;
    logic [MISS_W-1:0]  r_retry_limit;

    logic               r_in_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [WORD_W-1:0]  r_word;
    logic               r_last;

    logic               r_out_valid;
    t_result            r_out;
    logic               r_skid_valid;
    t_result            r_skid;

    logic               in_take;
    logic               process;
    logic               out_pop;
    t_result            result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RESET;
            r_retry_limit   <= RETRY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_TIMEOUT) begin
                r_timeout_ticks <= i_cfg_data[TIMER_W-1:0];
            end else if (i_cfg_index == CFG_RETRY) begin
                r_retry_limit <= i_cfg_data[MISS_W-1:0];
            end
        end
    end

    // process only when the skid register is free, so a result always has a home
    assign process = r_in_valid && !r_skid_valid;
    assign o_stall = r_in_valid && r_skid_valid;
    assign in_take = i_valid && !o_stall;
    assign out_pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= i_kind;
            r_word <= i_word;
            r_last <= i_last;
        end
    end

    sws_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (process),
        .i_kind          (r_kind),
        .i_word          (r_word),
        .i_last          (r_last),
        .i_timeout_ticks (r_timeout_ticks),
        .i_retry_limit   (r_retry_limit),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain skid into the output register
            if (out_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (process) begin
            if (r_out_valid && !out_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (process) begin
            if (r_out_valid && !out_pop) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_send     = r_out.send;
    assign o_send_seq = r_out.send_seq;
    assign o_outcome  = r_out.outcome;

endmodule
